### hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg - shared types and constants of the generational handle allocator
// Widths, codes and the slot memory word used by the top level and the
// request execution logic.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int SLOT_DEPTH = 1024;
   localparam int GEN_BITS   = 16;
   localparam int IDX_W      = $clog2(SLOT_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CFG_W      = 11;
   localparam int FUNC_W     = 2;
   localparam int STAT_W     = 2;
   localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // head value that marks an empty free list
   localparam logic [CNT_W-1:0]    LIST_EMPTY = CNT_W'(SLOT_DEPTH);
   localparam logic [GEN_BITS-1:0] GEN_TOP    = '1;
   localparam logic [GEN_BITS-1:0] GEN_FIRST  = GEN_BITS'(1);
   localparam logic [CFG_W-1:0]    MAX_RESET  = CFG_W'(1024);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE  = 2'd0,
      FUNC_DESTROY = 2'd1,
      FUNC_QUERY   = 2'd2
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_LIMIT = 2'd1,
      ST_STALE = 2'd2
   } status_type;

   // one word of the slot memory
   typedef struct packed {
      logic                live;
      logic [CNT_W-1:0]    next;
      logic [GEN_BITS-1:0] gen;
   } slot_type;

   // request plus current state, presented to the execution logic
   typedef struct packed {
      func_type            func;
      logic [IDX_W-1:0]    hidx;
      logic [GEN_BITS-1:0] hgen;
      slot_type            rd;
      logic [CNT_W-1:0]    head;
      logic [CNT_W-1:0]    slots_used;
      logic [CNT_W-1:0]    live_total;
      logic [CFG_W-1:0]    slot_limit;
   } ctx_type;

   // state updates and result of one request
   typedef struct packed {
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      slot_type            wr_data;
      logic [CNT_W-1:0]    head;
      logic [CNT_W-1:0]    slots_used;
      logic [CNT_W-1:0]    live_total;
      status_type          status;
      logic [IDX_W-1:0]    out_index;
      logic [GEN_BITS-1:0] out_gen;
      logic                alive;
   } upd_type;

endpackage

### hdl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator - slot index plus generation handle allocator
// Hands out, retires and checks handles; free slots are kept on a linked
// free list held in the slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): func selects create, destroy or query; the
//   handle fields matter for destroy and query. A transfer happens on a
//   clock edge with req_valid high and req_stall low.
//   Response channel (rsp_*): one result per request, in request order, with
//   status, the new handle (create), the alive flag (query) and the live
//   count after the request.
//   csr_wr_en / csr_wr_data write the slot limit, the cap on appended slots;
//   write it only while no request is in flight.
// Sequence:
//   On the transfer edge the slot memory is read into a register; at the
//   write-back the entry is written back and the result lands in the output
//   register. Only one request is in flight, so the next request is not
//   taken until the last one has been written back.
//   A held result does not block the next transfer in; only the write-back
//   waits while the output register is still full and stalled.
// Reset: the free list is empty, no slot is in use, the live count is zero
//   and the slot limit is 1024. The slot memory needs no clearing: entries at
//   or above the in-use count are never trusted.
// ----------------------------------------------------------------------------
module generational_handle_allocator
   import gha_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [IDX_W-1:0]    req_handle_index,
   input  logic [GEN_BITS-1:0] req_handle_generation,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]    rsp_out_index,
   output logic [GEN_BITS-1:0] rsp_out_generation,
   output logic                rsp_alive,
   output logic [CNT_W-1:0]    rsp_live_count,
   // configuration
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data
);

   // slot memory: live flag, free-list link and generation per slot
   slot_type slot_mem [SLOT_DEPTH];

   // control state
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    head_ff;
   logic [CNT_W-1:0]    slots_used_ff;
   logic [CNT_W-1:0]    live_total_ff;
   logic [CFG_W-1:0]    slot_limit_ff;

   // request held for the write-back cycle
   func_type            func_ff;
   logic [IDX_W-1:0]    hidx_ff;
   logic [GEN_BITS-1:0] hgen_ff;
   slot_type            rd_ff;

   // output register payload
   status_type          status_ff;
   logic [IDX_W-1:0]    out_index_ff;
   logic [GEN_BITS-1:0] out_gen_ff;
   logic                alive_ff;
   logic [CNT_W-1:0]    live_count_ff;

   logic                req_fire;
   logic                exec_fire;
   logic [IDX_W-1:0]    rd_addr;
   ctx_type             ctx;
   upd_type             upd;

   // one request in flight at a time; the read happens on the transfer edge
   assign req_stall = busy_ff;
   assign req_fire  = req_valid && !busy_ff;
   // write back once the output register is free or being drained
   assign exec_fire = busy_ff && (!rsp_valid_ff || !rsp_stall);

   // create reads the free-list head, the others read the addressed slot
   assign rd_addr = (func_type'(req_func) == FUNC_CREATE) ? head_ff[IDX_W-1:0]
                                                          : req_handle_index;

   assign busy_in      = req_fire || (busy_ff && !exec_fire);
   assign rsp_valid_in = exec_fire || (rsp_valid_ff && rsp_stall);

   always_comb begin
      ctx.func       = func_ff;
      ctx.hidx       = hidx_ff;
      ctx.hgen       = hgen_ff;
      ctx.rd         = rd_ff;
      ctx.head       = head_ff;
      ctx.slots_used = slots_used_ff;
      ctx.live_total = live_total_ff;
      ctx.slot_limit = slot_limit_ff;
   end

   gha_exec u_exec (
      .ctx (ctx),
      .upd (upd)
   );

   // slot memory: read on transfer, write on write-back; the two never meet
   // in the same cycle, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= slot_mem[rd_addr];
      end
      if (exec_fire && upd.wr_en) begin
         slot_mem[upd.wr_addr] <= upd.wr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= LIST_EMPTY;
         slots_used_ff <= '0;
         live_total_ff <= '0;
         slot_limit_ff <= MAX_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            head_ff       <= upd.head;
            slots_used_ff <= upd.slots_used;
            live_total_ff <= upd.live_total;
         end
         if (csr_wr_en) begin
            slot_limit_ff <= csr_wr_data;
         end
      end
   end

   // capture the request on transfer, hold it until write-back
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= func_type'(req_func);
         hidx_ff <= req_handle_index;
         hgen_ff <= req_handle_generation;
      end
   end

   // output register: load on write-back, hold while stalled
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         status_ff     <= upd.status;
         out_index_ff  <= upd.out_index;
         out_gen_ff    <= upd.out_gen;
         alive_ff      <= upd.alive;
         live_count_ff <= upd.live_total;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_index      = out_index_ff;
   assign rsp_out_generation = out_gen_ff;
   assign rsp_alive          = alive_ff;
   assign rsp_live_count     = live_count_ff;

endmodule

### hdl/gha_exec.sv
// ----------------------------------------------------------------------------
// gha_exec - request execution
// Decides the write-back word, the new list head and counters, and the
// result of one request from the slot word read for it.
// ----------------------------------------------------------------------------
module gha_exec
   import gha_pkg::*;
(
   input  ctx_type ctx,
   output upd_type upd
);

   logic                handle_ok;
   logic                from_free;
   logic                can_append;
   logic [GEN_BITS-1:0] gen_up;

   always_comb begin
      handle_ok  = (ctx.hgen != '0) && ({1'b0, ctx.hidx} < ctx.slots_used)
                   && ctx.rd.live && (ctx.rd.gen == ctx.hgen);
      from_free  = ctx.head < LIST_EMPTY;
      can_append = (ctx.slots_used < LIST_EMPTY)
                   && (LIM_W'(ctx.slots_used) < LIM_W'(ctx.slot_limit));
      // saturate: a slot at the top generation is retired
      gen_up     = (ctx.rd.gen != GEN_TOP) ? ctx.rd.gen + GEN_FIRST : ctx.rd.gen;

      upd            = '0;
      upd.wr_addr    = ctx.hidx;
      upd.wr_data    = ctx.rd;
      upd.head       = ctx.head;
      upd.slots_used = ctx.slots_used;
      upd.live_total = ctx.live_total;
      upd.status     = ST_OK;

      unique case (ctx.func)
         FUNC_CREATE: begin
            priority if (from_free) begin
               upd.wr_en      = 1'b1;
               upd.wr_addr    = ctx.head[IDX_W-1:0];
               upd.wr_data    = '{live: 1'b1, next: LIST_EMPTY, gen: ctx.rd.gen};
               upd.head       = ctx.rd.next;
               upd.live_total = ctx.live_total + CNT_W'(1);
               upd.out_index  = ctx.head[IDX_W-1:0];
               upd.out_gen    = ctx.rd.gen;
            end else if (can_append) begin
               upd.wr_en      = 1'b1;
               upd.wr_addr    = ctx.slots_used[IDX_W-1:0];
               upd.wr_data    = '{live: 1'b1, next: LIST_EMPTY, gen: GEN_FIRST};
               upd.slots_used = ctx.slots_used + CNT_W'(1);
               upd.live_total = ctx.live_total + CNT_W'(1);
               upd.out_index  = ctx.slots_used[IDX_W-1:0];
               upd.out_gen    = GEN_FIRST;
            end else begin
               upd.status = ST_LIMIT;
            end
         end
         FUNC_DESTROY: begin
            if (handle_ok) begin
               upd.wr_en           = 1'b1;
               upd.wr_data.live    = 1'b0;
               upd.wr_data.gen     = gen_up;
               upd.wr_data.next    = LIST_EMPTY;
               if (gen_up != GEN_TOP) begin
                  upd.wr_data.next = ctx.head;
                  upd.head         = {1'b0, ctx.hidx};
               end
               if (ctx.live_total != '0) begin
                  upd.live_total = ctx.live_total - CNT_W'(1);
               end
            end else begin
               upd.status = ST_STALE;
            end
         end
         FUNC_QUERY: begin
            upd.alive = handle_ok;
         end
         default: begin
         end
      endcase
   end

endmodule
